FILE: rtl/bsb_pkg.sv
// Shared types and constants for the separable RGB box blur.
// No dependencies; imported by bsb_divider, separable_box_blur_rgb_top and the testbench.
package bsb_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int MAX_RADIUS_DEF = 15;

   localparam int CH_N    = 3;
   localparam int CHAN_W  = 8;
   localparam int PIXEL_W = CH_N * CHAN_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUR_RADIUS  = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_CHECK,
      S_HREAD,
      S_VSETUP,
      S_VREAD,
      S_DSTART,
      S_DWAIT,
      S_OUT
   } bsb_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bsb_div_stat_type;

endpackage

FILE: rtl/bsb_divider.sv
// Three-lane restoring divider, one quotient bit per cycle per lane.
// Depends on bsb_pkg.
module bsb_divider #(
   parameter int DIVIDEND_W = 13,
   parameter int DIVISOR_W  = 5
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [bsb_pkg::CH_N-1:0][DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]                    divisor,
   output logic [bsb_pkg::CH_N-1:0][DIVIDEND_W-1:0] quotient,
   output bsb_pkg::bsb_div_stat_type               stat
);
   import bsb_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                                busy_ff;
   logic                                done_ff;
   logic [STEP_W-1:0]                   step_ff;
   logic [DIVISOR_W-1:0]                div_ff;
   logic [CH_N-1:0][DIVISOR_W-1:0]      rem_ff;
   logic [CH_N-1:0][DIVISOR_W-1:0]      rem_in;
   logic [CH_N-1:0][DIVIDEND_W-1:0]     quo_ff;
   logic [CH_N-1:0][DIVIDEND_W-1:0]     quo_in;
   logic [CH_N-1:0][DIVISOR_W:0]        trial;

   always_comb begin
      for (int i = 0; i < CH_N; i++) begin
         trial[i] = {rem_ff[i], quo_ff[i][DIVIDEND_W-1]};
         if (trial[i] >= {1'b0, div_ff}) begin
            rem_in[i] = DIVISOR_W'(trial[i] - {1'b0, div_ff});
            quo_in[i] = {quo_ff[i][DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in[i] = trial[i][DIVISOR_W-1:0];
            quo_in[i] = {quo_ff[i][DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: rtl/separable_box_blur_rgb_top.sv
// Separable RGB box blur: one transaction at a time, window sums read from memories.
// Time per transaction grows with each horizontal mean over nh pixels, each vertical mean
// over nv rows and the divider width SUM_W (13 by default), and with any wait while the
// previous result is still held on rsp_; it is set by the one-read-per-cycle memory ports
// and the bit-serial divider.
// The result for pixel n leaves with transaction n + R*W + R. Reset is synchronous and clears
// control state only; pixel and mean memories are not cleared and need no clearing pass.
// Depends on bsb_pkg and bsb_divider.
module separable_box_blur_rgb_top #(
   parameter int MAX_WIDTH  = bsb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bsb_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = bsb_pkg::MAX_RADIUS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bsb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bsb_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_opcode,
   input  logic [7:0]                       req_red_in,
   input  logic [7:0]                       req_green_in,
   input  logic [7:0]                       req_blue_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_red_out,
   output logic [7:0]                       rsp_green_out,
   output logic [7:0]                       rsp_blue_out,
   output logic                             rsp_frame_end
);
   import bsb_pkg::*;

   localparam int WIN_ROWS   = 2 * MAX_RADIUS + 1;
   localparam int PTR_W      = (WIN_ROWS > 1) ? $clog2(WIN_ROWS) : 1;
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int HW         = $clog2(MAX_HEIGHT + 1);
   localparam int RRW        = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
   localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int TW         = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int LAG_MAX    = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1;
   localparam int LW         = (LAG_MAX > 1) ? $clog2(LAG_MAX) : 1;
   localparam int KW         = $clog2(MAX_WIDTH * MAX_HEIGHT + LAG_MAX);
   localparam int SUM_W      = $clog2(WIN_ROWS * 255 + 1);
   localparam int CNT_W      = $clog2(WIN_ROWS + 1);
   localparam int MEAN_DEPTH = WIN_ROWS * MAX_WIDTH;
   localparam int MEAN_AW    = (MEAN_DEPTH > 1) ? $clog2(MEAN_DEPTH) : 1;
   localparam int HX_W       = ((CW > RRW) ? CW : RRW) + 1;
   localparam int VX_W       = ((RW > RRW) ? RW : RRW) + 1;

   bsb_state_type state_ff, state_in;

   logic [11:0]           cfg_w_ff;
   logic [12:0]           cfg_h_ff;
   logic [3:0]            cfg_r_ff;
   logic [WW-1:0]         cur_w_ff;
   logic [HW-1:0]         cur_h_ff;
   logic [RRW-1:0]        cur_r_ff;
   logic [TW-1:0]         total_ff;
   logic [LW-1:0]         lag_ff;
   logic [KW-1:0]         k_ff;
   logic [PTR_W-1:0]      wp_ff;
   logic [CW-1:0]         h_col_ff;
   logic [PTR_W-1:0]      h_rowmod_ff;
   logic [PTR_W-1:0]      h_pmod_ff;
   logic [CW-1:0]         v_col_ff;
   logic [RW-1:0]         v_row_ff;
   logic [PTR_W-1:0]      v_rowmod_ff;
   logic                  v_act_ff;
   logic                  last_ff;
   logic                  phase_ff;
   logic                  op_ff;
   logic [PIXEL_W-1:0]    pix_ff;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [CNT_W-1:0]      issue_left_ff;
   logic                  pend_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CH_N-1:0][SUM_W-1:0] sums_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                  rsp_end_ff;

   logic [PIXEL_W-1:0]    raw_mem [WIN_ROWS];
   logic [PIXEL_W-1:0]    mean_mem [MEAN_DEPTH];
   logic [PIXEL_W-1:0]    raw_rdata_ff;
   logic [PIXEL_W-1:0]    mean_rdata_ff;
   logic [PIXEL_W-1:0]    acc_data;
   logic [PIXEL_W-1:0]    mean_wdata;
   logic [MEAN_AW-1:0]    mean_raddr, mean_waddr;

   logic                  accept, slot_free, raw_we, mean_we, div_start;
   logic                  in_frame, ignore_item, h_act, v_act, is_last, read_done;
   logic [KW-1:0]         tot_k, lag_k, r_k;
   logic [WW-1:0]         w_clamp;
   logic [HW-1:0]         h_clamp;
   logic [RRW-1:0]        r_clamp;

   logic [HX_W-1:0]       hcol_x, hr_x, hwm1_x, hd_x, hsum_x, hhi_x;
   logic [CNT_W-1:0]      hcnt;
   logic [PTR_W-1:0]      hd_p, hstart;
   logic [VX_W-1:0]       vrow_x, vr_x, vhm1_x, vd_x, vsum_x, vhi_x;
   logic [CNT_W-1:0]      vcnt;
   logic [PTR_W-1:0]      vd_p, vstart;

   logic [CH_N-1:0][SUM_W-1:0] quotient;
   bsb_div_stat_type           div_stat;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (32'(p) == WIN_ROWS - 1) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= 12'd1;
         cfg_h_ff <= 13'd1;
         cfg_r_ff <= 4'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_w_ff <= csr_wdata[11:0];
            CSR_FRAME_HEIGHT: cfg_h_ff <= csr_wdata[12:0];
            CSR_BLUR_RADIUS:  cfg_r_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign w_clamp = (cfg_w_ff == '0) ? WW'(1) :
                    (32'(cfg_w_ff) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_w_ff);
   assign h_clamp = (cfg_h_ff == '0) ? HW'(1) :
                    (32'(cfg_h_ff) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_h_ff);
   assign r_clamp = (32'(cfg_r_ff) > MAX_RADIUS) ? RRW'(MAX_RADIUS) : RRW'(cfg_r_ff);

   // ---------------- decisions ----------------
   assign tot_k       = KW'(total_ff);
   assign lag_k       = KW'(lag_ff);
   assign r_k         = KW'(cur_r_ff);
   assign in_frame    = k_ff < tot_k;
   assign ignore_item = in_frame && (op_ff == OP_DRAIN);
   assign h_act       = (k_ff >= r_k) && (k_ff < tot_k + r_k);
   assign v_act       = (k_ff >= lag_k) && (k_ff < tot_k + lag_k);
   assign is_last     = (k_ff == tot_k + lag_k - 1'b1);
   assign read_done   = (issue_left_ff == '0) && !pend_ff;
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   // horizontal window, clipped to the row
   assign hcol_x = HX_W'(h_col_ff);
   assign hr_x   = HX_W'(cur_r_ff);
   assign hwm1_x = HX_W'(cur_w_ff) - 1'b1;
   assign hd_x   = (hcol_x >= hr_x) ? hr_x : hcol_x;
   assign hsum_x = hcol_x + hr_x;
   assign hhi_x  = (hsum_x > hwm1_x) ? hwm1_x : hsum_x;
   assign hcnt   = CNT_W'(hhi_x - (hcol_x - hd_x) + 1'b1);
   assign hd_p   = PTR_W'(hd_x);
   assign hstart = (h_pmod_ff >= hd_p) ? PTR_W'(h_pmod_ff - hd_p) :
                   PTR_W'(32'(h_pmod_ff) + WIN_ROWS - 32'(hd_p));

   // vertical window, clipped to the frame
   assign vrow_x = VX_W'(v_row_ff);
   assign vr_x   = VX_W'(cur_r_ff);
   assign vhm1_x = VX_W'(cur_h_ff) - 1'b1;
   assign vd_x   = (vrow_x >= vr_x) ? vr_x : vrow_x;
   assign vsum_x = vrow_x + vr_x;
   assign vhi_x  = (vsum_x > vhm1_x) ? vhm1_x : vsum_x;
   assign vcnt   = CNT_W'(vhi_x - (vrow_x - vd_x) + 1'b1);
   assign vd_p   = PTR_W'(vd_x);
   assign vstart = (v_rowmod_ff >= vd_p) ? PTR_W'(v_rowmod_ff - vd_p) :
                   PTR_W'(32'(v_rowmod_ff) + WIN_ROWS - 32'(vd_p));

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_PREP;
         S_PREP:   state_in = S_CHECK;
         S_CHECK: begin
            if (ignore_item)  state_in = S_IDLE;
            else if (h_act)   state_in = S_HREAD;
            else if (v_act)   state_in = S_VSETUP;
            else              state_in = S_IDLE;
         end
         S_HREAD:  if (read_done) state_in = S_DSTART;
         S_VSETUP: state_in = S_VREAD;
         S_VREAD:  if (read_done) state_in = S_DSTART;
         S_DSTART: state_in = S_DWAIT;
         S_DWAIT: begin
            if (div_stat.done) begin
               if (phase_ff)      state_in = S_OUT;
               else if (v_act_ff) state_in = S_VSETUP;
               else               state_in = S_IDLE;
            end
         end
         S_OUT:    if (slot_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == S_IDLE);
      div_start = (state_ff == S_DSTART);
      raw_we    = (state_ff == S_CHECK) && in_frame && !ignore_item;
      mean_we   = (state_ff == S_DWAIT) && div_stat.done && !phase_ff;
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------- frame control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_w_ff    <= WW'(1);
         cur_h_ff    <= HW'(1);
         cur_r_ff    <= '0;
         k_ff        <= '0;
         wp_ff       <= '0;
         h_col_ff    <= '0;
         h_rowmod_ff <= '0;
         h_pmod_ff   <= '0;
         v_col_ff    <= '0;
         v_row_ff    <= '0;
         v_rowmod_ff <= '0;
         v_act_ff    <= 1'b0;
         last_ff     <= 1'b0;
         phase_ff    <= 1'b0;
         issue_left_ff <= '0;
         pend_ff     <= 1'b0;
         rd_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept && (k_ff == '0)) begin
            cur_w_ff <= w_clamp;
            cur_h_ff <= h_clamp;
            cur_r_ff <= r_clamp;
         end

         if ((state_ff == S_CHECK) && !ignore_item) begin
            k_ff     <= k_ff + 1'b1;
            wp_ff    <= ptr_inc(wp_ff);
            v_act_ff <= v_act;
            last_ff  <= is_last;
            if (h_act) begin
               phase_ff      <= 1'b0;
               rd_ptr_ff     <= hstart;
               issue_left_ff <= hcnt;
            end
         end

         if (state_ff == S_VSETUP) begin
            phase_ff      <= 1'b1;
            rd_ptr_ff     <= vstart;
            issue_left_ff <= vcnt;
         end

         if ((state_ff == S_HREAD) || (state_ff == S_VREAD)) begin
            pend_ff <= (issue_left_ff != '0);
            if (issue_left_ff != '0) begin
               issue_left_ff <= issue_left_ff - 1'b1;
               rd_ptr_ff     <= ptr_inc(rd_ptr_ff);
            end
         end else begin
            pend_ff <= 1'b0;
         end

         if (mean_we) begin
            h_pmod_ff <= ptr_inc(h_pmod_ff);
            if (WW'(h_col_ff) == cur_w_ff - 1'b1) begin
               h_col_ff    <= '0;
               h_rowmod_ff <= ptr_inc(h_rowmod_ff);
            end else begin
               h_col_ff <= h_col_ff + 1'b1;
            end
         end

         if (rsp_valid_ff && rsp_ready && !((state_ff == S_OUT) && slot_free))
            rsp_valid_ff <= 1'b0;

         if ((state_ff == S_OUT) && slot_free) begin
            rsp_valid_ff <= 1'b1;
            if (last_ff) begin
               // frame done: next transaction starts a new frame
               k_ff        <= '0;
               wp_ff       <= '0;
               h_col_ff    <= '0;
               h_rowmod_ff <= '0;
               h_pmod_ff   <= '0;
               v_col_ff    <= '0;
               v_row_ff    <= '0;
               v_rowmod_ff <= '0;
            end else if (WW'(v_col_ff) == cur_w_ff - 1'b1) begin
               v_col_ff    <= '0;
               v_row_ff    <= v_row_ff + 1'b1;
               v_rowmod_ff <= ptr_inc(v_rowmod_ff);
            end else begin
               v_col_ff <= v_col_ff + 1'b1;
            end
         end
      end
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_opcode;
         pix_ff <= {req_red_in, req_green_in, req_blue_in};
      end
      if (state_ff == S_PREP) begin
         total_ff <= TW'(cur_w_ff * cur_h_ff);
         lag_ff   <= LW'(cur_r_ff * cur_w_ff + cur_r_ff);
      end
      if ((state_ff == S_CHECK) || (state_ff == S_VSETUP)) begin
         sums_ff <= '0;
         cnt_ff  <= (state_ff == S_CHECK) ? hcnt : vcnt;
      end else if (pend_ff) begin
         for (int i = 0; i < CH_N; i++) begin
            sums_ff[i] <= sums_ff[i] + SUM_W'(acc_data[PIXEL_W-1-CHAN_W*i -: CHAN_W]);
         end
      end
      if ((state_ff == S_OUT) && slot_free) begin
         rsp_red_ff   <= quotient[0][CHAN_W-1:0];
         rsp_green_ff <= quotient[1][CHAN_W-1:0];
         rsp_blue_ff  <= quotient[2][CHAN_W-1:0];
         rsp_end_ff   <= last_ff;
      end
   end

   assign acc_data   = phase_ff ? mean_rdata_ff : raw_rdata_ff;
   assign mean_wdata = {quotient[0][CHAN_W-1:0], quotient[1][CHAN_W-1:0],
                        quotient[2][CHAN_W-1:0]};
   assign mean_raddr = MEAN_AW'(32'(rd_ptr_ff) * MAX_WIDTH + 32'(v_col_ff));
   assign mean_waddr = MEAN_AW'(32'(h_rowmod_ff) * MAX_WIDTH + 32'(h_col_ff));

   // last 2R+1 raw pixels, indexed by pixel number modulo the window
   always_ff @(posedge clock) begin
      if (raw_we) raw_mem[wp_ff] <= pix_ff;
      raw_rdata_ff <= raw_mem[rd_ptr_ff];
   end

   // horizontal means of the last 2R+1 rows
   always_ff @(posedge clock) begin
      if (mean_we) mean_mem[mean_waddr] <= mean_wdata;
      mean_rdata_ff <= mean_mem[mean_raddr];
   end

   bsb_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sums_ff),
      .divisor  (cnt_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out  = rsp_blue_ff;
   assign rsp_frame_end = rsp_end_ff;

   // ---------------- assertions ----------------
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(rd_ptr_ff) < WIN_ROWS)
      else $error("window pointer out of range");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DWAIT))
      else $error("divider finished outside wait state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (k_ff < tot_k + lag_k))
      else $error("item count ran past end of frame");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && slot_free) |=> rsp_valid_ff)
      else $error("result not presented after output step");

endmodule

FILE: tb/tb_separable_box_blur_rgb_top.sv
// Self-checking testbench for separable_box_blur_rgb_top: a cycle-free predictor of the
// separable RGB box blur checks every response transaction. Depends on bsb_pkg and the RTL.
module tb_separable_box_blur_rgb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bsb_pkg::*;

   localparam int WIN_ROWS   = 2 * MAX_RADIUS_DEF + 1;
   localparam int IDLE_WAIT  = 200;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } blur_pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_opcode;
   logic [7:0]            req_red_in;
   logic [7:0]            req_green_in;
   logic [7:0]            req_blue_in;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_red_out;
   logic [7:0]            rsp_green_out;
   logic [7:0]            rsp_blue_out;
   logic                  rsp_frame_end;

   separable_box_blur_rgb_top dut (.*);

   // predictor state
   logic [23:0]  raw_win [WIN_ROWS];
   logic [23:0]  hmean_rows [WIN_ROWS * MAX_WIDTH_DEF];
   int unsigned  pix_count;
   int unsigned  lat_w, lat_h, lat_r;
   int unsigned  reg_w, reg_h, reg_r;

   blur_pixel_type  pending_pixels [$];
   int           gap_pct;
   int           stall_pct;
   int           mismatches;
   int           items_sent;
   int           results_seen;
   int           frames_done;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [23:0] box_avg(int unsigned rs, int unsigned gs, int unsigned bs,
                                           int unsigned cnt);
      logic [7:0] r, g, b;
      r = 8'(rs / cnt);
      g = 8'(gs / cnt);
      b = 8'(bs / cnt);
      return {r, g, b};
   endfunction

   function automatic void row_mean(int unsigned m);
      int unsigned row, col, lo, hi, rs, gs, bs;
      logic [23:0] p;
      row = m / lat_w;
      col = m % lat_w;
      lo = (col >= lat_r) ? col - lat_r : 0;
      hi = col + lat_r;
      if (hi > lat_w - 1) hi = lat_w - 1;
      rs = 0; gs = 0; bs = 0;
      for (int unsigned c = lo; c <= hi; c++) begin
         p = raw_win[(row * lat_w + c) % WIN_ROWS];
         rs += p[23:16];
         gs += p[15:8];
         bs += p[7:0];
      end
      hmean_rows[(row % WIN_ROWS) * MAX_WIDTH_DEF + col] = box_avg(rs, gs, bs, hi - lo + 1);
   endfunction

   function automatic logic [23:0] column_mean(int unsigned n);
      int unsigned row, col, lo, hi, rs, gs, bs;
      logic [23:0] p;
      row = n / lat_w;
      col = n % lat_w;
      lo = (row >= lat_r) ? row - lat_r : 0;
      hi = row + lat_r;
      if (hi > lat_h - 1) hi = lat_h - 1;
      rs = 0; gs = 0; bs = 0;
      for (int unsigned r = lo; r <= hi; r++) begin
         p = hmean_rows[(r % WIN_ROWS) * MAX_WIDTH_DEF + col];
         rs += p[23:16];
         gs += p[15:8];
         bs += p[7:0];
      end
      return box_avg(rs, gs, bs, hi - lo + 1);
   endfunction

   // advance the predictor by one accepted request transaction
   function automatic void predict_blur(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned total, lag, k, n;
      logic [23:0] p;
      blur_pixel_type e;
      if (pix_count == 0) begin
         lat_w = (reg_w < 1) ? 1 : (reg_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : reg_w;
         lat_h = (reg_h < 1) ? 1 : (reg_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : reg_h;
         lat_r = (reg_r > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : reg_r;
      end
      total = lat_w * lat_h;
      lag = lat_r * lat_w + lat_r;
      k = pix_count;
      if (k < total) begin
         if (op != OP_PIXEL) return;   // early drain is dropped
         raw_win[k % WIN_ROWS] = {r, g, b};
      end
      if (k >= lat_r && k - lat_r < total) row_mean(k - lat_r);
      if (k >= lag && k - lag < total) begin
         n = k - lag;
         p = column_mean(n);
         e.red = p[23:16];
         e.green = p[15:8];
         e.blue = p[7:0];
         e.frame_end = (n == total - 1);
         pending_pixels.push_back(e);
         pix_count = e.frame_end ? 0 : k + 1;
         if (e.frame_end) frames_done++;
         return;
      end
      pix_count = k + 1;
   endfunction

   // response side: check each transaction, then pick the next ready
   always @(posedge clock) begin
      blur_pixel_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_frame_end};
         results_seen++;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h at %0t", got, $realtime);
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: exp r=%h g=%h b=%h end=%b, got r=%h g=%h b=%h end=%b",
                           $realtime, want.red, want.green, want.blue, want.frame_end,
                           got.red, got.green, got.blue, got.frame_end);
            end
         end
      end
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   task automatic send_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      predict_blur(op, r, g, b);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:  reg_w = val & 12'hFFF;
         CSR_FRAME_HEIGHT: reg_h = val & 13'h1FFF;
         CSR_BLUR_RADIUS:  reg_r = val & 4'hF;
         default: ;
      endcase
   endtask

   // mode: 0 random, 1 all zero, 2 all ones, 3 random mix of the extremes
   function automatic logic [7:0] chan_value(int mode);
      case (mode)
         1: return 8'h00;
         2: return 8'hFF;
         3: return $urandom_range(1) ? 8'hFF : 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   // configure, stream one frame, then flush with drains or stray pixels
   task automatic blur_frame(int unsigned w, int unsigned h, int unsigned r, int mode,
                             int noise_pct);
      int unsigned total;
      wait_idle();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      write_csr(CSR_BLUR_RADIUS, r);
      total = ((reg_w < 1) ? 1 : (reg_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : reg_w) *
              ((reg_h < 1) ? 1 : (reg_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : reg_h);
      for (int unsigned i = 0; i < total; i++) begin
         if ($urandom_range(99) < noise_pct)
            send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
         send_item(OP_PIXEL, chan_value(mode), chan_value(mode), chan_value(mode));
      end
      while (pix_count != 0)
         send_item(($urandom_range(99) < 30) ? OP_PIXEL : OP_DRAIN,
                   8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic test_directed();
      blur_frame(1, 1, 0, 1, 0);
      blur_frame(1, 1, 0, 2, 0);
      blur_frame(3, 3, 1, 3, 30);   // early drains mixed in, stray pixels in flush
      blur_frame(2, 3, 15, 2, 0);   // radius larger than the frame
   endtask

   task automatic test_register_limits();
      blur_frame(0, 0, 0, 0, 0);        // zero saturates to one
      blur_frame(4096 + 5, 2, 1, 0, 0); // upper width bits are dropped
      blur_frame(1, 20, 15, 0, 10);
   endtask

   task automatic test_random(int gap, int stall, int budget);
      int stop_at;
      gap_pct = gap;
      stall_pct = stall;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         blur_frame($urandom_range(1, 12), $urandom_range(1, 8),
                    ($urandom_range(9) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 3),
                    ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0,
                    ($urandom_range(3) == 0) ? 10 : 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_opcode = OP_PIXEL;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      gap_pct = 0;
      stall_pct = 0;
      mismatches = 0;
      items_sent = 0;
      results_seen = 0;
      frames_done = 0;
      pix_count = 0;
      reg_w = 1; reg_h = 1; reg_r = 0;
      lat_w = 1; lat_h = 1; lat_r = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_limits();
      test_random(0, 0, 400);
      test_random(82, 0, 400);
      test_random(0, 82, 400);
      test_random(25, 25, 400);
      wait_idle();

      $display("covered %0d request transactions, %0d responses, %0d frames",
               items_sent, results_seen, frames_done);
      $display("radius 0..15, saturated and masked sizes, early drains and stray pixels, four idle mixes");
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, pending_pixels.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
